>>> design/longest_bounded_range_window_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded-range window block
// Concurrent assertion wrappers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LONGEST_BOUNDED_RANGE_WINDOW_ASSERT_SVH
`define LONGEST_BOUNDED_RANGE_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define LBRW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LBRW_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define LBRW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> design/lbrw_pkg.sv
// ----------------------------------------------------------------------------
// lbrw_pkg
// Widths, depth and shared types of the bounded-range window block.
// ----------------------------------------------------------------------------
package lbrw_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    // Positions run modulo twice the depth so a full window is representable.
    localparam int POS_W    = ADDR_W + 1;
    localparam int SAMPLE_W = 16;
    localparam int LIMIT_W  = 16;
    localparam int LEN_W    = 11;
    localparam int BEST_W   = 32;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1);
    localparam logic [POS_W-1:0]   FULL_LEN    = POS_W'(DEPTH);

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [SAMPLE_W-1:0] value;
    } q_entry_t;

    typedef struct packed {
        logic     clear;
        logic     push;
        logic     pop_front;
        logic     pop_back;
        q_entry_t entry;
    } q_cmd_t;

    typedef struct packed {
        logic     busy;
        logic     nonempty;
        q_entry_t front;
        q_entry_t back;
    } q_stat_t;

endpackage

>>> design/lbrw_in_if.sv
// ----------------------------------------------------------------------------
// lbrw_in_if
// Sample channel: valid/ready handshake with sample and first flag.
// ----------------------------------------------------------------------------
interface lbrw_in_if;

    logic                          valid;
    logic                          ready;
    logic [lbrw_pkg::SAMPLE_W-1:0] sample;
    logic                          first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);

endinterface

>>> design/lbrw_out_if.sv
// ----------------------------------------------------------------------------
// lbrw_out_if
// Result channel: valid/ready handshake with best and current lengths and an overflow flag.
// ----------------------------------------------------------------------------
interface lbrw_out_if;

    logic                        valid;
    logic                        ready;
    logic [lbrw_pkg::BEST_W-1:0] best_length;
    logic [lbrw_pkg::LEN_W-1:0]  window_length;
    logic                        overflow;

    modport source (output valid, output best_length, output window_length,
                    output overflow, input ready);
    modport sink   (input valid, input best_length, input window_length,
                    input overflow, output ready);

endinterface

>>> design/lbrw_queue.sv
// ----------------------------------------------------------------------------
// lbrw_queue
// Monotonic deque of (position, value) entries kept in a synchronous RAM,
// with the front and back entries cached in registers.
// ----------------------------------------------------------------------------
module lbrw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  lbrw_pkg::q_cmd_t cmd,
    output lbrw_pkg::q_stat_t stat
);

    lbrw_pkg::q_entry_t mem [lbrw_pkg::DEPTH];

    logic [lbrw_pkg::ADDR_W-1:0] head_reg, head_next;
    logic [lbrw_pkg::POS_W-1:0]  count_reg, count_next;
    logic                        pend_front_reg, pend_front_next;
    logic                        pend_back_reg, pend_back_next;
    lbrw_pkg::q_entry_t          front_reg, front_next;
    lbrw_pkg::q_entry_t          back_reg, back_next;
    lbrw_pkg::q_entry_t          rdata_reg;

    logic                        wr_en;
    logic [lbrw_pkg::ADDR_W-1:0] wr_addr;
    logic                        rd_en;
    logic [lbrw_pkg::ADDR_W-1:0] rd_addr;

    always_comb
    begin
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_front_next = 1'b0;
        pend_back_next  = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = head_reg + count_reg[lbrw_pkg::ADDR_W-1:0];
        rd_en           = 1'b0;
        rd_addr         = head_reg + lbrw_pkg::ADDR_W'(1);

        // A refresh read issued last cycle lands in the cached entry now.
        if (pend_front_reg)
        begin
            front_next = rdata_reg;
        end
        if (pend_back_reg)
        begin
            back_next = rdata_reg;
        end

        if (cmd.clear)
        begin
            head_next  = '0;
            count_next = '0;
        end
        else if (cmd.push)
        begin
            wr_en      = 1'b1;
            count_next = count_reg + lbrw_pkg::POS_W'(1);
            back_next  = cmd.entry;
            if (count_reg == '0)
            begin
                front_next = cmd.entry;
            end
        end
        else if (cmd.pop_front)
        begin
            head_next  = head_reg + lbrw_pkg::ADDR_W'(1);
            count_next = count_reg - lbrw_pkg::POS_W'(1);
            if (count_reg == lbrw_pkg::POS_W'(2))
            begin
                front_next = back_reg;
            end
            else if (count_reg > lbrw_pkg::POS_W'(2))
            begin
                rd_en           = 1'b1;
                rd_addr         = head_reg + lbrw_pkg::ADDR_W'(1);
                pend_front_next = 1'b1;
            end
        end
        else if (cmd.pop_back)
        begin
            count_next = count_reg - lbrw_pkg::POS_W'(1);
            if (count_reg == lbrw_pkg::POS_W'(2))
            begin
                back_next = front_reg;
            end
            else if (count_reg > lbrw_pkg::POS_W'(2))
            begin
                rd_en          = 1'b1;
                rd_addr        = head_reg
                               + lbrw_pkg::ADDR_W'(count_reg - lbrw_pkg::POS_W'(2));
                pend_back_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            count_reg      <= '0;
            pend_front_reg <= 1'b0;
            pend_back_reg  <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            count_reg      <= count_next;
            pend_front_reg <= pend_front_next;
            pend_back_reg  <= pend_back_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (wr_en)
        begin
            mem[wr_addr] <= cmd.entry;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign stat.busy     = pend_front_reg | pend_back_reg;
    assign stat.nonempty = (count_reg != '0);
    assign stat.front    = front_reg;
    assign stat.back     = back_reg;

endmodule

>>> design/longest_bounded_range_window.sv
// Timing: a new sample is taken only in IDLE, once the previous one has been pushed and shrunk.
// The push step waits, for the slower deque, on each back pop, each RAM refresh read and a refresh
// after a depth drop; the shrink step waits on each front pop and each refresh.
// Each sample enters each deque once and leaves it at most once.
// Reset: deques empty, positions and best length zero, range_limit = 1; no clearing pass.
// ----------------------------------------------------------------------------
// longest_bounded_range_window
// Longest window whose maximum minus minimum stays within range_limit.
// ----------------------------------------------------------------------------
//
// The window is [left, right) over a running sample position. Two monotonic
// deques, each held in its own single-port-read RAM, track the window maximum
// (values strictly decreasing from front to back) and the window minimum
// (values strictly increasing). Every entry stores its position together with
// its sample value, so no separate sample ring is needed: the deques only ever
// read values they hold themselves.
//
// Per transaction the controller walks through three states:
//   IDLE   - takes the sample. A first flag clears both deques and the
//            counters. If the window already holds DEPTH samples, the oldest
//            one is dropped by advancing left and popping any deque front that
//            sits at the old left position; overflow is flagged.
//   PUSH   - pops dominated entries from each deque's back, then pushes the
//            new sample. Both deques work in parallel and each waits while its
//            cached back entry is being refreshed from RAM.
//   SHRINK - while front(max) - front(min) exceeds range_limit, the front with
//            the older position is popped and left jumps just past it. This is
//            the same as stepping left one sample at a time. When the range
//            fits, the lengths go to the output register.
// The output register frees the controller: the next sample is accepted
// while the previous result still waits for its consumer. A new result only
// stalls SHRINK if the previous one has not yet been taken.
//
module longest_bounded_range_window (
    input  logic                           clk,
    input  logic                           rst_n,
    lbrw_in_if.sink                        item,
    lbrw_out_if.source                     result,
    input  logic                           cfg_write,
    input  logic [lbrw_pkg::LIMIT_W-1:0]   cfg_data
);

`include "longest_bounded_range_window_assert.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PUSH,
        ST_SHRINK
    } state_t;

    state_t                        state_reg, state_next;
    logic [lbrw_pkg::POS_W-1:0]    l_pos_reg, l_pos_next;
    logic [lbrw_pkg::POS_W-1:0]    r_pos_reg, r_pos_next;
    logic [lbrw_pkg::POS_W-1:0]    best_reg, best_next;
    logic [lbrw_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                          ovf_reg, ovf_next;
    logic                          max_done_reg, max_done_next;
    logic                          min_done_reg, min_done_next;
    logic [lbrw_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic                          out_valid_reg, out_valid_next;
    logic [lbrw_pkg::POS_W-1:0]    out_best_reg, out_best_next;
    logic [lbrw_pkg::LEN_W-1:0]    out_len_reg, out_len_next;
    logic                          out_ovf_reg, out_ovf_next;

    lbrw_pkg::q_cmd_t  max_cmd, min_cmd;
    lbrw_pkg::q_stat_t max_stat, min_stat;

    logic [lbrw_pkg::POS_W-1:0]    win_len;
    logic [lbrw_pkg::SAMPLE_W-1:0] spread;
    logic [lbrw_pkg::POS_W-1:0]    max_ofs;
    logic [lbrw_pkg::POS_W-1:0]    min_ofs;
    lbrw_pkg::q_entry_t            new_entry;

    lbrw_queue u_max_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (max_cmd),
        .stat  (max_stat)
    );

    lbrw_queue u_min_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (min_cmd),
        .stat  (min_stat)
    );

    assign win_len   = r_pos_reg - l_pos_reg;
    // The max front is the window maximum and the min front its minimum, so
    // this difference never goes negative.
    assign spread    = max_stat.front.value - min_stat.front.value;
    // Ages relative to left tell which front is older, across the wrap.
    assign max_ofs   = max_stat.front.pos - l_pos_reg;
    assign min_ofs   = min_stat.front.pos - l_pos_reg;
    assign new_entry = '{pos: r_pos_reg, value: sample_reg};

    assign item.ready           = (state_reg == ST_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.best_length   = lbrw_pkg::BEST_W'(out_best_reg);
    assign result.window_length = out_len_reg;
    assign result.overflow      = out_ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        l_pos_next     = l_pos_reg;
        r_pos_next     = r_pos_reg;
        best_next      = best_reg;
        sample_next    = sample_reg;
        ovf_next       = ovf_reg;
        max_done_next  = max_done_reg;
        min_done_next  = min_done_reg;
        limit_next     = limit_reg;
        out_valid_next = out_valid_reg;
        out_best_next  = out_best_reg;
        out_len_next   = out_len_reg;
        out_ovf_next   = out_ovf_reg;

        max_cmd       = '0;
        min_cmd       = '0;
        max_cmd.entry = new_entry;
        min_cmd.entry = new_entry;

        if (cfg_write)
        begin
            limit_next = cfg_data;
        end

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item.valid)
                begin
                    sample_next   = item.sample;
                    ovf_next      = 1'b0;
                    max_done_next = 1'b0;
                    min_done_next = 1'b0;
                    state_next    = ST_PUSH;
                    if (item.first)
                    begin
                        max_cmd.clear = 1'b1;
                        min_cmd.clear = 1'b1;
                        l_pos_next    = '0;
                        r_pos_next    = '0;
                        best_next     = '0;
                    end
                    else if (win_len == lbrw_pkg::FULL_LEN)
                    begin
                        // Window is at store depth: drop the oldest sample.
                        ovf_next   = 1'b1;
                        l_pos_next = l_pos_reg + lbrw_pkg::POS_W'(1);
                        max_cmd.pop_front = max_stat.nonempty
                                          && (max_stat.front.pos == l_pos_reg);
                        min_cmd.pop_front = min_stat.nonempty
                                          && (min_stat.front.pos == l_pos_reg);
                    end
                end
            end

            ST_PUSH:
            begin
                if (!max_done_reg && !max_stat.busy)
                begin
                    if (max_stat.nonempty && (max_stat.back.value <= sample_reg))
                    begin
                        max_cmd.pop_back = 1'b1;
                    end
                    else
                    begin
                        max_cmd.push  = 1'b1;
                        max_done_next = 1'b1;
                    end
                end
                if (!min_done_reg && !min_stat.busy)
                begin
                    if (min_stat.nonempty && (min_stat.back.value >= sample_reg))
                    begin
                        min_cmd.pop_back = 1'b1;
                    end
                    else
                    begin
                        min_cmd.push  = 1'b1;
                        min_done_next = 1'b1;
                    end
                end
                if (max_done_next && min_done_next)
                begin
                    r_pos_next = r_pos_reg + lbrw_pkg::POS_W'(1);
                    state_next = ST_SHRINK;
                end
            end

            ST_SHRINK:
            begin
                if (!max_stat.busy && !min_stat.busy)
                begin
                    if (spread > limit_reg)
                    begin
                        if (max_ofs < min_ofs)
                        begin
                            max_cmd.pop_front = 1'b1;
                            l_pos_next = max_stat.front.pos + lbrw_pkg::POS_W'(1);
                        end
                        else
                        begin
                            min_cmd.pop_front = 1'b1;
                            l_pos_next = min_stat.front.pos + lbrw_pkg::POS_W'(1);
                        end
                    end
                    else if (!out_valid_reg || result.ready)
                    begin
                        if (win_len > best_reg)
                        begin
                            best_next = win_len;
                        end
                        out_valid_next = 1'b1;
                        out_best_next  = (win_len > best_reg) ? win_len : best_reg;
                        out_len_next   = lbrw_pkg::LEN_W'(win_len);
                        out_ovf_next   = ovf_reg;
                        state_next     = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            l_pos_reg     <= '0;
            r_pos_reg     <= '0;
            best_reg      <= '0;
            sample_reg    <= '0;
            ovf_reg       <= 1'b0;
            max_done_reg  <= 1'b0;
            min_done_reg  <= 1'b0;
            limit_reg     <= lbrw_pkg::LIMIT_RESET;
            out_valid_reg <= 1'b0;
            out_best_reg  <= '0;
            out_len_reg   <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            l_pos_reg     <= l_pos_next;
            r_pos_reg     <= r_pos_next;
            best_reg      <= best_next;
            sample_reg    <= sample_next;
            ovf_reg       <= ovf_next;
            max_done_reg  <= max_done_next;
            min_done_reg  <= min_done_next;
            limit_reg     <= limit_next;
            out_valid_reg <= out_valid_next;
            out_best_reg  <= out_best_next;
            out_len_reg   <= out_len_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // The best length always covers the window reported with it.
    `LBRW_ASSERT_IMPLY(a_best_covers_window, clk, rst_n, result.valid, (result.best_length >= lbrw_pkg::BEST_W'(result.window_length)), "best length below window length")

    // The controller never sends a command while a queue refreshes its cache.
    `LBRW_ASSERT_IMPLY(a_max_cmd_when_busy, clk, rst_n, max_stat.busy, !(max_cmd.push || max_cmd.pop_front || max_cmd.pop_back || max_cmd.clear), "command to busy max queue")
    `LBRW_ASSERT_IMPLY(a_min_cmd_when_busy, clk, rst_n, min_stat.busy, !(min_cmd.push || min_cmd.pop_front || min_cmd.pop_back || min_cmd.clear), "command to busy min queue")

    // The window never grows past the store depth.
    `LBRW_ASSERT_NEXT(a_window_bounded, clk, rst_n, 1'b1, (win_len <= lbrw_pkg::FULL_LEN), "window longer than store depth")

endmodule
